### rtl/vdp_pkg.sv
// ----------------------------------------------------------------------------
// vdp_pkg - shared types and constants for the version string parser
// Character classes, field limits, the phase encoding and the item and
// result records that pass between the parser stages.
// ----------------------------------------------------------------------------
package vdp_pkg;

   localparam logic [7:0]  DOT_CHAR     = 8'h2E;
   localparam logic [7:0]  DIGIT_LO     = 8'h30;
   localparam logic [7:0]  DIGIT_HI     = 8'h39;
   localparam int          ACC_W        = 34;
   localparam logic [33:0] SMALL_MAX    = 34'd255;
   localparam logic [33:0] BUILD_MAX    = 34'h0_FFFF_FFFF;
   localparam logic [3:0]  SMALL_DIGITS = 4'd3;
   localparam logic [3:0]  BUILD_DIGITS = 4'd10;

   typedef enum logic [1:0] {
      PH_MAJOR = 2'd0,
      PH_MINOR = 2'd1,
      PH_PATCH = 2'd2,
      PH_BUILD = 2'd3
   } phase_type;

   // one character of the string
   typedef struct packed {
      logic       is_last;
      logic [7:0] char_code;
   } item_type;

   // one parsed string
   typedef struct packed {
      logic        parse_ok;
      logic [31:0] build_num;
      logic [7:0]  patch_num;
      logic [7:0]  minor_num;
      logic [7:0]  major_num;
   } result_type;

endpackage

### rtl/vdp_in_reg.sv
// ----------------------------------------------------------------------------
// vdp_in_reg - request input register
// Holds one character request; refills in the same cycle it drains.
// ----------------------------------------------------------------------------
module vdp_in_reg
   import vdp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   input  logic       advance,
   output logic       in_valid,
   output item_type   item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     take;

   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in          = 1'b1;
         item_in.char_code = req_tdata;
         item_in.is_last   = req_tlast;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign in_valid = valid_ff;
   assign item     = item_ff;

endmodule

### rtl/vdp_parse.sv
// ----------------------------------------------------------------------------
// vdp_parse - per-character field parser
// Phase state machine, digit accumulator and field holds; forms the result
// on the last character of a string and then returns to the start state.
// ----------------------------------------------------------------------------
module vdp_parse
   import vdp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  item_type   item,
   output logic       res_valid,
   output result_type res
);

   phase_type        phase_ff, phase_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [7:0]       major_ff, major_in;
   logic [7:0]       minor_ff, minor_in;
   logic [7:0]       patch_ff, patch_in;
   logic             err_ff, err_in;

   logic             is_digit, is_dot;
   logic [3:0]       digit;
   logic [3:0]       limit;
   logic [ACC_W-1:0] acc_step;
   logic             small_bad;
   logic [7:0]       small_val;
   logic             ok;

   assign is_digit  = (item.char_code >= DIGIT_LO) && (item.char_code <= DIGIT_HI);
   assign is_dot    = (item.char_code == DOT_CHAR);
   assign digit     = is_digit ? 4'(item.char_code - DIGIT_LO) : 4'd0;
   assign limit     = (phase_ff == PH_BUILD) ? BUILD_DIGITS : SMALL_DIGITS;
   // acc * 10 + digit as two shifts and adds
   assign acc_step  = (acc_ff << 3) + (acc_ff << 1) + ACC_W'(digit);
   assign small_bad = (cnt_ff == 4'd0) || (acc_ff > SMALL_MAX);
   assign small_val = small_bad ? 8'd0 : acc_ff[7:0];

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_MAJOR: if (is_dot) phase_in = PH_MINOR;
         PH_MINOR: if (is_dot) phase_in = PH_PATCH;
         PH_PATCH: if (!is_digit) phase_in = PH_BUILD;
         PH_BUILD: phase_in = PH_BUILD;
         default:  phase_in = PH_MAJOR;
      endcase
   end

   // datapath for the current character
   always_comb begin
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      major_in = major_ff;
      minor_in = minor_ff;
      patch_in = patch_ff;
      err_in   = err_ff;
      if (is_digit) begin
         if (cnt_ff >= limit) begin
            err_in = 1'b1;            // overlong run: flag, keep value
         end else begin
            acc_in = acc_step;
            cnt_in = cnt_ff + 4'd1;
         end
      end else if ((phase_ff == PH_PATCH) ||
                   (is_dot && (phase_ff == PH_MAJOR || phase_ff == PH_MINOR))) begin
         // close a small field
         if (small_bad) begin
            err_in = 1'b1;
         end
         if (phase_ff == PH_MAJOR) begin
            major_in = small_val;
         end
         if (phase_ff == PH_MINOR) begin
            minor_in = small_val;
         end
         if (phase_ff == PH_PATCH) begin
            patch_in = small_val;
         end
         cnt_in = 4'd0;
         acc_in = '0;
      end else begin
         err_in = 1'b1;
      end
   end

   assign ok = !err_in && (phase_in == PH_BUILD) && (cnt_in != 4'd0) &&
               (acc_in <= BUILD_MAX);

   // result outputs
   always_comb begin
      res_valid     = fire && item.is_last;
      res.parse_ok  = ok;
      res.major_num = ok ? major_in : 8'd0;
      res.minor_num = ok ? minor_in : 8'd0;
      res.patch_num = ok ? patch_in : 8'd0;
      res.build_num = ok ? acc_in[31:0] : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset || (fire && item.is_last)) begin
         phase_ff <= PH_MAJOR;
         cnt_ff   <= 4'd0;
         acc_ff   <= '0;
         major_ff <= 8'd0;
         minor_ff <= 8'd0;
         patch_ff <= 8'd0;
         err_ff   <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         acc_ff   <= acc_in;
         major_ff <= major_in;
         minor_ff <= minor_in;
         patch_ff <= patch_in;
         err_ff   <= err_in;
      end
   end

`ifndef SYNTHESIS
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      fire && item.is_last |=> (phase_ff == PH_MAJOR) && (cnt_ff == 4'd0) && !err_ff)
      else $error("parser state not cleared after last character");

   a_build_count: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= BUILD_DIGITS)
      else $error("digit count beyond build limit");

   a_small_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_BUILD) |-> (cnt_ff <= SMALL_DIGITS))
      else $error("digit count beyond small field limit");
`endif

endmodule

### rtl/vdp_out_reg.sv
// ----------------------------------------------------------------------------
// vdp_out_reg - response output register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module vdp_out_reg
   import vdp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  result_type  res,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,
   output logic        rsp_tuser
);

   logic       valid_ff, valid_in;
   result_type res_ff, res_in;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (load) begin
         valid_in = 1'b1;
         res_in   = res;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {res_ff.build_num, res_ff.patch_num,
                        res_ff.minor_num, res_ff.major_num};
   assign rsp_tuser  = res_ff.parse_ok;

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> (!valid_ff || rsp_tready))
      else $error("result loaded over a pending response");
`endif

endmodule

### rtl/dotted_version_string_parser_top.sv
// ----------------------------------------------------------------------------
// dotted_version_string_parser_top - dotted version string parser
// Takes MAJOR.MINOR.PATCH<skip>BUILD one character per request and returns
// the four numbers and a well-formed flag on the last character.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-----------------------------------
//  req     | in  | req_tvalid/req_tready  | tdata[7:0] char_code, tlast is_last
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata major/minor/patch/build,
//          |     |                        | tuser parse_ok
//
//  One character per cycle sustained unless a last character must wait for
//  the response slot: a request register feeds the field parser, whose
//  combinational update (acc*10 + digit, limit compares) writes the parser
//  state and, on the last character, the response register.
//  Characters that are not last keep flowing while a response waits; a last
//  character stalls in the request register until the response slot frees.
//  Synchronous active-high reset clears all control and parser state.
//
module dotted_version_string_parser_top
   import vdp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,   // is_last
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [7:0] major_num, [15:8] minor_num,
                                    // [23:16] patch_num, [55:24] build_num
   output logic        rsp_tuser    // [0] parse_ok
);

   logic       in_valid;
   item_type   item;
   logic       advance;
   logic       res_valid;
   result_type res;

   // a character moves into the parser unless it ends a string and the
   // response slot is still occupied
   assign advance = in_valid && (!item.is_last || !rsp_tvalid || rsp_tready);

   vdp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .advance    (advance),
      .in_valid   (in_valid),
      .item       (item)
   );

   vdp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .item      (item),
      .res_valid (res_valid),
      .res       (res)
   );

   vdp_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (res_valid),
      .res        (res),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
